// ===== hdl/slps_pkg.sv =====
// ----------------------------------------------------------------------------
// slps_pkg
// shared types and constants for the status lamp pattern sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slps_pkg;

   // slot ring
   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);

   // lamps and signals
   localparam int LAMP_COUNT = 4;
   localparam int SIGNAL_W   = 7;

   localparam int LAMP_LOCK      = 0;
   localparam int LAMP_ATTENTION = 1;
   localparam int LAMP_RADIO     = 2;
   localparam int LAMP_WINDOW    = 3;

   localparam int SIG_UNLOCKED       = 0;
   localparam int SIG_FAULT          = 1;
   localparam int SIG_UNCOMMISSIONED = 2;
   localparam int SIG_RANGING        = 3;
   localparam int SIG_SESSION        = 4;
   localparam int SIG_UPDATE_WINDOW  = 5;
   localparam int SIG_PROVISIONING   = 6;

   // blink patterns, msb shown first
   localparam logic [SLOT_COUNT-1:0] PAT_DARK      = 16'h0000;
   localparam logic [SLOT_COUNT-1:0] PAT_LIT       = 16'hFFFF;
   localparam logic [SLOT_COUNT-1:0] PAT_HEARTBEAT = 16'h8000;
   localparam logic [SLOT_COUNT-1:0] PAT_HALF      = 16'hFF00;
   localparam logic [SLOT_COUNT-1:0] PAT_ONE       = 16'hF0F0;
   localparam logic [SLOT_COUNT-1:0] PAT_TWO       = 16'hCCCC;
   localparam logic [SLOT_COUNT-1:0] PAT_FOUR      = 16'hAAAA;

   // request function codes
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_SIGNAL = 1'b1;

   // control register map
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LAMP_COUNT;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAMP_READY = 1'd1;

   typedef struct packed {
      logic [SIGNAL_W-1:0]   signals;
      logic [SLOT_W-1:0]     slot;
      logic [LAMP_COUNT-1:0] held;
      logic [LAMP_COUNT-1:0] ready;
      logic                  heartbeat;
   } frame_req_type;

   typedef struct packed {
      logic [LAMP_COUNT-1:0] levels;
      logic [SLOT_W-1:0]     slot;
      logic                  moving;
   } frame_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/slps_frame.sv =====
// ----------------------------------------------------------------------------
// slps_frame
// renders one frame: picks each lamp's pattern and samples the current slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slps_frame (
   input  slps_pkg::frame_req_type frame_req,
   output slps_pkg::frame_rsp_type frame_rsp
);
   import slps_pkg::*;

   localparam int SLOT_LAST = SLOT_COUNT - 1;

   logic [SLOT_COUNT-1:0] pattern [LAMP_COUNT];
   logic [SLOT_W-1:0]     bit_index;
   logic [LAMP_COUNT-1:0] moving_lamp;
   logic [LAMP_COUNT-1:0] levels;

   // priority pick per lamp
   always_comb begin
      pattern[LAMP_LOCK] = frame_req.signals[SIG_UNLOCKED] ? PAT_LIT :
                           (frame_req.heartbeat ? PAT_HEARTBEAT : PAT_DARK);
      pattern[LAMP_ATTENTION] = frame_req.signals[SIG_FAULT] ? PAT_LIT :
                                (frame_req.signals[SIG_UNCOMMISSIONED] ? PAT_HALF : PAT_DARK);
      pattern[LAMP_RADIO] = frame_req.signals[SIG_RANGING] ? PAT_FOUR :
                            (frame_req.signals[SIG_SESSION] ? PAT_ONE : PAT_DARK);
      pattern[LAMP_WINDOW] = frame_req.signals[SIG_UPDATE_WINDOW] ? PAT_TWO :
                             (frame_req.signals[SIG_PROVISIONING] ? PAT_LIT : PAT_DARK);
   end

   // slot 0 is the msb
   assign bit_index = SLOT_W'(SLOT_LAST) - frame_req.slot;

   always_comb begin
      for (int i = 0; i < LAMP_COUNT; i++) begin
         levels[i]      = frame_req.ready[i] ? pattern[i][bit_index] : frame_req.held[i];
         moving_lamp[i] = (pattern[i] != PAT_DARK) && (pattern[i] != PAT_LIT);
      end
   end

   assign frame_rsp.levels = levels;
   assign frame_rsp.slot   = frame_req.slot;
   assign frame_rsp.moving = |moving_lamp;

endmodule

`default_nettype wire

// ===== hdl/status_led_pattern_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer_unit
// four-lamp status blink sequencer driven by a mask of active signals
// ----------------------------------------------------------------------------
// A request transaction is either a slot tick or a signal set/clear. Each one
// is captured in an input register, handled there by one level of logic and,
// when it yields a frame, lands in the response register, so a frame passes
// through the input register and then the response register. One request is
// taken every cycle while req_stall is low; the response register with its
// input stage lets the next request in while a finished frame still waits on
// rsp_stall. A tick while the run is stopped and a signal that leaves the mask
// unchanged give no response. The control registers are always ready and
// should be written only while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module status_led_pattern_sequencer_unit (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_func,
   input  wire  [slps_pkg::SIGNAL_W-1:0]      req_signal_mask,
   input  wire                                req_assert_bits,
   // response channel
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [slps_pkg::LAMP_COUNT-1:0]    rsp_lamp_levels,
   output logic [slps_pkg::SLOT_W-1:0]        rsp_slot_shown,
   output logic                               rsp_still_moving,
   // control register write channel
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [slps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [slps_pkg::CSR_DATA_W-1:0]    csr_data
);
   import slps_pkg::*;

   // control registers
   logic                  heartbeat_ff, heartbeat_in;
   logic [LAMP_COUNT-1:0] lamp_ready_ff, lamp_ready_in;

   // input stage
   logic                  in_valid_ff, in_valid_in;
   logic                  in_func_ff;
   logic [SIGNAL_W-1:0]   in_mask_ff;
   logic                  in_assert_ff;

   // sequencer state
   logic [SIGNAL_W-1:0]   active_ff, active_in;
   logic [SLOT_W-1:0]     phase_ff, phase_in;
   logic                  running_ff, running_in;
   logic [LAMP_COUNT-1:0] held_ff, held_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   frame_rsp_type         rsp_data_ff;

   logic                  out_free;
   logic                  fire;
   logic                  is_signal;
   logic [SIGNAL_W-1:0]   after_mask;
   logic                  emit;
   logic                  load;
   frame_req_type         frame_req;
   frame_rsp_type         frame_rsp;

   // handshakes
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign fire      = in_valid_ff && out_free;

   // request decode
   assign is_signal  = (in_func_ff == FUNC_SIGNAL);
   assign after_mask = in_assert_ff ? (active_ff | in_mask_ff) : (active_ff & ~in_mask_ff);
   // tick renders only while running, signal only when the mask really moves
   assign emit = is_signal ? (after_mask != active_ff) : running_ff;
   assign load = fire && emit;

   // a changed mask restarts at slot 0
   always_comb begin
      frame_req.signals   = is_signal ? after_mask : active_ff;
      frame_req.slot      = is_signal ? '0 : phase_ff;
      frame_req.held      = held_ff;
      frame_req.ready     = lamp_ready_ff;
      frame_req.heartbeat = heartbeat_ff;
   end

   slps_frame u_frame (
      .frame_req (frame_req),
      .frame_rsp (frame_rsp)
   );

   // next state
   always_comb begin
      heartbeat_in  = heartbeat_ff;
      lamp_ready_in = lamp_ready_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEARTBEAT:  heartbeat_in  = csr_data[0];
            CSR_LAMP_READY: lamp_ready_in = csr_data;
            default:        ;
         endcase
      end

      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end

      active_in  = active_ff;
      phase_in   = phase_ff;
      running_in = running_ff;
      held_in    = held_ff;
      if (load) begin
         active_in  = frame_req.signals;
         // slot ring wraps naturally at its width
         phase_in   = frame_rsp.slot + SLOT_W'(1);
         running_in = frame_rsp.moving;
         held_in    = frame_rsp.levels;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         heartbeat_ff  <= 1'b1;
         lamp_ready_ff <= '1;
         in_valid_ff   <= 1'b0;
         active_ff     <= '0;
         phase_ff      <= '0;
         running_ff    <= 1'b1;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         heartbeat_ff  <= heartbeat_in;
         lamp_ready_ff <= lamp_ready_in;
         in_valid_ff   <= in_valid_in;
         active_ff     <= active_in;
         phase_ff      <= phase_in;
         running_ff    <= running_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_func_ff   <= req_func;
         in_mask_ff   <= req_signal_mask;
         in_assert_ff <= req_assert_bits;
      end
      if (load) begin
         rsp_data_ff <= frame_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lamp_levels  = rsp_data_ff.levels;
   assign rsp_slot_shown   = rsp_data_ff.slot;
   assign rsp_still_moving = rsp_data_ff.moving;

   // checks

   // a rendered frame is always offered on the response channel next cycle
   assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("rendered frame not presented");

   // run flag and phase follow the frame just shown
   assert property (@(posedge clock) disable iff (reset)
      load |=> (running_ff == rsp_still_moving) &&
               (phase_ff == rsp_slot_shown + SLOT_W'(1)))
      else $error("sequencer state out of step with frame");

   // lamps that are not ready keep their previous level
   assert property (@(posedge clock) disable iff (reset)
      load |=> (((rsp_lamp_levels ^ $past(held_ff)) & ~$past(lamp_ready_ff)) == '0))
      else $error("unready lamp changed level");

   // requests are held back only when the input stage is occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("spurious request stall");

endmodule

`default_nettype wire

// ===== bench/status_led_pattern_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer_unit_tb
// self-checking bench for the four-lamp status blink sequencer
// ----------------------------------------------------------------------------
// Drives tick and signal transactions into the sequencer and keeps its own
// copy of the signal mask, slot phase, run flag and lamp levels to work out
// every frame the block should emit. Frames are compared field by field in
// arrival order. The lamp registers are rewritten between phases, once the
// block has gone quiet; three regimes set how often the channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module status_led_pattern_sequencer_unit_tb;

   localparam int LAMP_W    = slps_pkg::LAMP_COUNT;
   localparam int SIG_W     = slps_pkg::SIGNAL_W;
   localparam int SLOT_BITS = slps_pkg::SLOT_W;
   localparam int SLOTS     = slps_pkg::SLOT_COUNT;

   // signal bit positions in the active mask
   localparam int BIT_UNLOCKED       = 0;
   localparam int BIT_FAULT          = 1;
   localparam int BIT_UNCOMMISSIONED = 2;
   localparam int BIT_RANGING        = 3;
   localparam int BIT_SESSION        = 4;
   localparam int BIT_UPDATE_WINDOW  = 5;
   localparam int BIT_PROVISIONING   = 6;

   // blink shapes, leftmost bit shown in slot 0
   localparam logic [SLOTS-1:0] SHAPE_DARK   = 16'h0000;
   localparam logic [SLOTS-1:0] SHAPE_SOLID  = 16'hFFFF;
   localparam logic [SLOTS-1:0] SHAPE_BLIP   = 16'h8000;
   localparam logic [SLOTS-1:0] SHAPE_HALF   = 16'hFF00;
   localparam logic [SLOTS-1:0] SHAPE_1HZ    = 16'hF0F0;
   localparam logic [SLOTS-1:0] SHAPE_2HZ    = 16'hCCCC;
   localparam logic [SLOTS-1:0] SHAPE_4HZ    = 16'hAAAA;

   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int BLOCK_ITEMS   = 80;

   typedef struct packed {
      logic [LAMP_W-1:0]    levels;
      logic [SLOT_BITS-1:0] slot;
      logic                 moving;
   } lamp_frame_type;

   // ------------------------------------------------------------------------
   // frame scoreboard: mirrors the sequencer state and queues expected frames
   // ------------------------------------------------------------------------
   class lamp_frame_scoreboard;
      logic                 heartbeat_on;
      logic [LAMP_W-1:0]    ready_lamps;
      logic [SIG_W-1:0]     signals;
      logic [SLOT_BITS-1:0] phase;
      logic                 running;
      logic [LAMP_W-1:0]    lamp_state;
      lamp_frame_type       expected_frames[$];
      int                   mismatches;

      function new();
         heartbeat_on = 1'b1;
         ready_lamps  = '1;
         signals      = '0;
         phase        = '0;
         running      = 1'b1;
         lamp_state   = '0;
         mismatches   = 0;
      endfunction

      function void write_register(logic [slps_pkg::CSR_INDEX_W-1:0] idx,
                                   logic [slps_pkg::CSR_DATA_W-1:0] data);
         if (idx == slps_pkg::CSR_HEARTBEAT) begin
            heartbeat_on = data[0];
         end else if (idx == slps_pkg::CSR_LAMP_READY) begin
            ready_lamps = data[LAMP_W-1:0];
         end
      endfunction

      function logic [SLOTS-1:0] lamp_shape(int lamp);
         logic [SLOTS-1:0] shape;
         case (lamp)
            0: shape = signals[BIT_UNLOCKED] ? SHAPE_SOLID :
                       (heartbeat_on ? SHAPE_BLIP : SHAPE_DARK);
            1: shape = signals[BIT_FAULT] ? SHAPE_SOLID :
                       (signals[BIT_UNCOMMISSIONED] ? SHAPE_HALF : SHAPE_DARK);
            2: shape = signals[BIT_RANGING] ? SHAPE_4HZ :
                       (signals[BIT_SESSION] ? SHAPE_1HZ : SHAPE_DARK);
            default: shape = signals[BIT_UPDATE_WINDOW] ? SHAPE_2HZ :
                       (signals[BIT_PROVISIONING] ? SHAPE_SOLID : SHAPE_DARK);
         endcase
         return shape;
      endfunction

      function void render_frame();
         lamp_frame_type   frame;
         logic [SLOTS-1:0] shape;
         logic             moving;
         moving = 1'b0;
         for (int lamp = 0; lamp < LAMP_W; lamp++) begin
            shape = lamp_shape(lamp);
            if (ready_lamps[lamp]) begin
               lamp_state[lamp] = shape[SLOTS-1-int'(phase)];
            end
            if (shape != SHAPE_DARK && shape != SHAPE_SOLID) begin
               moving = 1'b1;
            end
         end
         frame.levels = lamp_state;
         frame.slot   = phase;
         frame.moving = moving;
         expected_frames.push_back(frame);
         phase   = phase + 1'b1;
         running = moving;
      endfunction

      // returns 1 when the transaction yields a frame
      function bit note_request(logic func, logic [SIG_W-1:0] mask, logic set_bits);
         logic [SIG_W-1:0] after;
         if (func == slps_pkg::FUNC_TICK) begin
            if (!running) begin
               return 1'b0;
            end
         end else begin
            after = set_bits ? (signals | mask) : (signals & ~mask);
            if (after == signals) begin
               return 1'b0;
            end
            signals = after;
            phase   = '0;
            running = 1'b1;
         end
         render_frame();
         return 1'b1;
      endfunction

      function void check_frame(lamp_frame_type got);
         lamp_frame_type want;
         if (expected_frames.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected frame: levels %h slot %0d moving %0d",
                        got.levels, got.slot, got.moving);
            end
            mismatches++;
            return;
         end
         want = expected_frames.pop_front();
         if (got.levels !== want.levels || got.slot !== want.slot ||
             got.moving !== want.moving) begin
            if (mismatches < 10) begin
               $display({"frame mismatch: want levels %h slot %0d moving %0d, ",
                         "got levels %h slot %0d moving %0d"},
                        want.levels, want.slot, want.moving,
                        got.levels, got.slot, got.moving);
            end
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block under test and its ports
   // ------------------------------------------------------------------------
   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic                                 req_func;
   logic [SIG_W-1:0]                     req_signal_mask;
   logic                                 req_assert_bits;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [LAMP_W-1:0]                    rsp_lamp_levels;
   logic [SLOT_BITS-1:0]                 rsp_slot_shown;
   logic                                 rsp_still_moving;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [slps_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [slps_pkg::CSR_DATA_W-1:0]      csr_data;

   status_led_pattern_sequencer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_signal_mask  (req_signal_mask),
      .req_assert_bits  (req_assert_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lamp_levels  (rsp_lamp_levels),
      .rsp_slot_shown   (rsp_slot_shown),
      .rsp_still_moving (rsp_still_moving),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   lamp_frame_scoreboard frames;
   int req_gap_pct;     // chance of a sender gap before each transaction
   int rsp_hold_pct;    // chance of the receiver stalling in a cycle
   int cycle_count;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake or a missing frame ends the run here
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= !reset && ($urandom_range(99) < rsp_hold_pct);
      end
   end

   // frames are taken at the next rising edge; at the falling edge every
   // signal involved is settled and equal to what that edge will see
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         frames.check_frame({rsp_lamp_levels, rsp_slot_shown, rsp_still_moving});
      end
   end

   // ------------------------------------------------------------------------
   // drivers; each task is entered and left just after a rising edge
   // ------------------------------------------------------------------------
   task automatic issue_request(input logic func, input logic [SIG_W-1:0] mask,
                                input logic set_bits, output bit framed);
      // random gap first; valid only drops if a gap is actually taken
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_signal_mask <= mask;
      req_assert_bits <= set_bits;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      framed = frames.note_request(func, mask, set_bits);
   endtask

   task automatic write_lamp_register(input logic [slps_pkg::CSR_INDEX_W-1:0] idx,
                                      input logic [slps_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      frames.write_register(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every expected frame, then hold the request valid low while the
   // pipeline clears, before the registers are touched
   task automatic settle();
      req_valid <= 1'b0;
      while (frames.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_lamps(input logic heartbeat, input logic [LAMP_W-1:0] ready);
      settle();
      write_lamp_register(slps_pkg::CSR_HEARTBEAT, {{(slps_pkg::CSR_DATA_W-1){1'b0}}, heartbeat});
      write_lamp_register(slps_pkg::CSR_LAMP_READY, ready);
   endtask

   task automatic run_directed();
      bit framed;
      issue_request(slps_pkg::FUNC_TICK, 7'h00, 1'b0, framed);     // heartbeat blip at slot 0
      issue_request(slps_pkg::FUNC_SIGNAL, 7'h01, 1'b1, framed);   // unlocked: all static, run stops
      issue_request(slps_pkg::FUNC_TICK, 7'h7F, 1'b1, framed);     // tick while stopped
      issue_request(slps_pkg::FUNC_SIGNAL, 7'h01, 1'b1, framed);   // set with no change
      issue_request(slps_pkg::FUNC_SIGNAL, 7'h7F, 1'b1, framed);   // every signal raised
      issue_request(slps_pkg::FUNC_TICK, 7'h00, 1'b0, framed);
      issue_request(slps_pkg::FUNC_SIGNAL, 7'h0B, 1'b0, framed);   // fall back to lower priorities
      issue_request(slps_pkg::FUNC_TICK, 7'h55, 1'b1, framed);
      issue_request(slps_pkg::FUNC_SIGNAL, 7'h7F, 1'b0, framed);   // all cleared, blip only
      // walk the whole slot ring and wrap
      for (int n = 0; n < SLOTS; n++) begin
         issue_request(slps_pkg::FUNC_TICK, 7'($urandom_range(127)), 1'($urandom_range(1)),
                       framed);
      end
   endtask

   // signal changes followed by runs of ticks, with random noise fields on
   // the ticks; every transaction sent counts towards the goal
   task automatic run_random(input int goal);
      int               made;
      int               ticks;
      bit               framed;
      logic [SIG_W-1:0] mask;
      made = 0;
      while (made < goal) begin
         if ($urandom_range(3) == 0) begin
            mask = 7'($urandom_range(127));
         end else begin
            mask = 7'(1) << $urandom_range(SIG_W-1);
         end
         issue_request(slps_pkg::FUNC_SIGNAL, mask, 1'($urandom_range(1)), framed);
         made++;
         ticks = ($urandom_range(4) == 0) ? $urandom_range(18, 24) : $urandom_range(6);
         repeat (ticks) begin
            issue_request(slps_pkg::FUNC_TICK, 7'($urandom_range(127)),
                          1'($urandom_range(1)), framed);
            made++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      frames          = new();
      req_gap_pct     = 18;
      rsp_hold_pct    = 67;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = slps_pkg::FUNC_TICK;
      req_signal_mask = '0;
      req_assert_bits = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = slps_pkg::CSR_HEARTBEAT;
      csr_data        = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed checks start from the reset state of the registers
      run_directed();

      // sender mostly busy, receiver mostly stalled
      program_lamps(1'b0, 4'hF);
      run_random(BLOCK_ITEMS);
      program_lamps(1'b1, 4'h0);
      run_random(BLOCK_ITEMS);

      // sender mostly idle, receiver mostly ready
      settle();
      req_gap_pct  = 67;
      rsp_hold_pct = 18;
      program_lamps(1'b1, 4'($urandom_range(15)));
      run_random(BLOCK_ITEMS);
      program_lamps(1'b0, 4'($urandom_range(15)));
      run_random(BLOCK_ITEMS);

      // full rate both ways
      settle();
      req_gap_pct  = 0;
      rsp_hold_pct = 0;
      program_lamps(1'b1, 4'hF);
      run_random(BLOCK_ITEMS);
      program_lamps(1'($urandom_range(1)), 4'($urandom_range(15)));
      run_random(BLOCK_ITEMS);

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (frames.mismatches == 0 && frames.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
